// ===== design/rsxb_pkg.sv =====
// Shared types and constants for the ROM sum, XOR and balance checker.
package rsxb_pkg;

  localparam int CFG_AW      = 20;
  localparam int TARGET_W    = 16;
  localparam int CMP_W       = 32;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  localparam logic [CFG_AW-1:0]   CHECK_ADDR_RST   = 20'h08100;
  localparam logic [CFG_AW-1:0]   START_ADDR_RST   = 20'h04000;
  localparam logic [CFG_AW-1:0]   SKIP_ADDR_RST    = 20'h08100;
  localparam logic [CFG_AW-1:0]   BALANCE_ADDR_RST = 20'h7fffa;
  localparam logic [TARGET_W-1:0] TARGET_RST       = 16'h5aa5;

  typedef enum logic [2:0] {
    REG_CHECK_ADDR   = 3'd0,
    REG_START_ADDR   = 3'd1,
    REG_SKIP_ADDR    = 3'd2,
    REG_BALANCE_ADDR = 3'd3,
    REG_TARGET       = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_AW-1:0]   check_addr;
    logic [CFG_AW-1:0]   start_addr;
    logic [CFG_AW-1:0]   skip_addr;
    logic [CFG_AW-1:0]   balance_addr;
    logic [TARGET_W-1:0] target;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  sum_computed;
    logic [7:0]  xor_computed;
    logic [7:0]  sum_stored;
    logic [7:0]  xor_stored;
    logic [15:0] word_sum;
    logic [15:0] balance_stored;
    logic [15:0] balance_fixed;
    logic        sum_bad;
    logic        xor_bad;
    logic        word_bad;
  } result_t;

endpackage

// ===== design/rsxb_if.sv =====
// Request and result channel interfaces of the ROM checker.
interface rsxb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rom_byte;
  logic       last_byte;

  modport source (output valid, rom_byte, last_byte, input ready);
  modport sink (input valid, rom_byte, last_byte, output ready);
endinterface

interface rsxb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  sum_computed;
  logic [7:0]  xor_computed;
  logic [7:0]  sum_stored;
  logic [7:0]  xor_stored;
  logic [15:0] word_sum;
  logic [15:0] balance_stored;
  logic [15:0] balance_fixed;
  logic        sum_bad;
  logic        xor_bad;
  logic        word_bad;

  modport source (
    output valid, sum_computed, xor_computed, sum_stored, xor_stored, word_sum,
           balance_stored, balance_fixed, sum_bad, xor_bad, word_bad,
    input  ready
  );
  modport sink (
    input  valid, sum_computed, xor_computed, sum_stored, xor_stored, word_sum,
           balance_stored, balance_fixed, sum_bad, xor_bad, word_bad,
    output ready
  );
endinterface

// ===== design/rsxb_cfg.sv =====
// APB-style configuration register file of the ROM checker.
module rsxb_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rsxb_pkg::PADDR_W-1:0] paddr,
  input  logic [rsxb_pkg::PDATA_W-1:0] pwdata,
  output logic [rsxb_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output rsxb_pkg::cfg_t               cfg
);
  import rsxb_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_addr   <= CHECK_ADDR_RST;
      cfg_r.start_addr   <= START_ADDR_RST;
      cfg_r.skip_addr    <= SKIP_ADDR_RST;
      cfg_r.balance_addr <= BALANCE_ADDR_RST;
      cfg_r.target       <= TARGET_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_CHECK_ADDR:   cfg_r.check_addr   <= pwdata[CFG_AW-1:0];
        REG_START_ADDR:   cfg_r.start_addr   <= pwdata[CFG_AW-1:0];
        REG_SKIP_ADDR:    cfg_r.skip_addr    <= pwdata[CFG_AW-1:0];
        REG_BALANCE_ADDR: cfg_r.balance_addr <= pwdata[CFG_AW-1:0];
        REG_TARGET:       cfg_r.target       <= pwdata[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CHECK_ADDR:   prdata = PDATA_W'(cfg_r.check_addr);
      REG_START_ADDR:   prdata = PDATA_W'(cfg_r.start_addr);
      REG_SKIP_ADDR:    prdata = PDATA_W'(cfg_r.skip_addr);
      REG_BALANCE_ADDR: prdata = PDATA_W'(cfg_r.balance_addr);
      REG_TARGET:       prdata = PDATA_W'(cfg_r.target);
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== design/rsxb_accum.sv =====
// Per-image accumulators: byte sum, byte XOR, word sum and captured check values.
module rsxb_accum #(
  parameter int ADDR_BITS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         rom_byte,
  input  logic               last_byte,
  input  rsxb_pkg::cfg_t     cfg,
  output rsxb_pkg::result_t  result
);
  import rsxb_pkg::*;

  localparam logic [CMP_W-1:0] AMASK = CMP_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [CMP_W-1:0] ALIGN = ~CMP_W'(3);

  logic [ADDR_BITS-1:0] byte_index_r;
  logic [7:0]           sum_acc_r,  sum_acc_nxt;
  logic [7:0]           xor_acc_r,  xor_acc_nxt;
  logic [15:0]          word_acc_r, word_acc_nxt;
  logic [7:0]           half_hi_r,  half_hi_nxt;
  logic [7:0]           sum_seen_r, sum_seen_nxt;
  logic [7:0]           xor_seen_r, xor_seen_nxt;
  logic [15:0]          bal_seen_r, bal_seen_nxt;

  logic [CMP_W-1:0] a, chk0, chk1, bal0, bal1, wbase, start_al, skip_al;
  logic             in_words;

  assign a        = CMP_W'(byte_index_r);
  assign chk0     = CMP_W'(cfg.check_addr);
  assign chk1     = (chk0 + CMP_W'(1)) & AMASK;
  assign bal0     = CMP_W'(cfg.balance_addr);
  assign bal1     = (bal0 + CMP_W'(1)) & AMASK;
  assign wbase    = a & ALIGN;
  assign start_al = CMP_W'(cfg.start_addr) & ALIGN;
  assign skip_al  = CMP_W'(cfg.skip_addr) & ALIGN;
  assign in_words = (wbase >= start_al) && (wbase != skip_al);

  always_comb begin
    sum_acc_nxt  = sum_acc_r;
    xor_acc_nxt  = xor_acc_r;
    word_acc_nxt = word_acc_r;
    half_hi_nxt  = half_hi_r;
    sum_seen_nxt = sum_seen_r;
    xor_seen_nxt = xor_seen_r;
    bal_seen_nxt = bal_seen_r;
    if (a != chk0 && a != chk1) begin
      sum_acc_nxt = sum_acc_r + rom_byte;
      xor_acc_nxt = xor_acc_r ^ rom_byte;
    end
    if (a == chk0) sum_seen_nxt = rom_byte;
    if (a == chk1) xor_seen_nxt = rom_byte;
    if (a == bal0) bal_seen_nxt[15:8] = rom_byte;
    if (a == bal1) bal_seen_nxt[7:0] = rom_byte;
    if (in_words) begin
      if (a[1:0] == 2'd2) half_hi_nxt = rom_byte;
      if (a[1:0] == 2'd3) word_acc_nxt = word_acc_r + {half_hi_r, rom_byte};
    end
  end

  always_comb begin
    result.sum_computed   = sum_acc_nxt;
    result.xor_computed   = xor_acc_nxt;
    result.sum_stored     = sum_seen_nxt;
    result.xor_stored     = xor_seen_nxt;
    result.word_sum       = word_acc_nxt;
    result.balance_stored = bal_seen_nxt;
    result.balance_fixed  = bal_seen_nxt + cfg.target - word_acc_nxt;
    result.sum_bad        = sum_acc_nxt != sum_seen_nxt;
    result.xor_bad        = xor_acc_nxt != xor_seen_nxt;
    result.word_bad       = word_acc_nxt != cfg.target;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      byte_index_r <= '0;
      sum_acc_r    <= '0;
      xor_acc_r    <= '0;
      word_acc_r   <= '0;
      half_hi_r    <= '0;
      sum_seen_r   <= '0;
      xor_seen_r   <= '0;
      bal_seen_r   <= '0;
    end else if (step) begin
      byte_index_r <= byte_index_r + ADDR_BITS'(1);
      sum_acc_r    <= sum_acc_nxt;
      xor_acc_r    <= xor_acc_nxt;
      word_acc_r   <= word_acc_nxt;
      half_hi_r    <= half_hi_nxt;
      sum_seen_r   <= sum_seen_nxt;
      xor_seen_r   <= xor_seen_nxt;
      bal_seen_r   <= bal_seen_nxt;
    end
  end

endmodule

// ===== design/rom_sum_xor_balance_checker.sv =====
// Top level of the ROM byte sum, XOR and word-sum balance checker.
//
//   channel   direction  handshake          payload
//   in_req    in         valid / ready      rom_byte, last_byte
//   out_res   out        valid / ready      sums, stored values, flags, balance_fixed
//   cfg       in         psel/penable/...   five registers at 4*index
//
// One byte per cycle sustained while no waiting result holds back a last byte.
// The byte lands in an input register, then one add/XOR/compare step updates the
// accumulators and loads the result register. Reset clears all image state.
// A waiting result only holds back a following last byte; other bytes flow on.
module rom_sum_xor_balance_checker #(
  parameter int ADDR_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  rsxb_in_if.sink                      in_req,
  rsxb_out_if.source                   out_res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rsxb_pkg::PADDR_W-1:0] paddr,
  input  logic [rsxb_pkg::PDATA_W-1:0] pwdata,
  output logic [rsxb_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import rsxb_pkg::*;

  cfg_t    cfg;
  result_t result;
  result_t out_r;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r;
  logic       out_free;
  logic       s1_go;

  assign out_free     = !out_valid_r || out_res.ready;
  assign s1_go        = s1_valid_r && (!s1_last_r || out_free);
  assign in_req.ready = !s1_valid_r || s1_go;

  rsxb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rsxb_accum #(.ADDR_BITS(ADDR_BITS)) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .rom_byte  (s1_byte_r),
    .last_byte (s1_last_r),
    .cfg       (cfg),
    .result    (result)
  );

  // hold the request until the accumulator step takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      s1_byte_r <= in_req.rom_byte;
      s1_last_r <= in_req.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_r <= result;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.sum_computed   = out_r.sum_computed;
  assign out_res.xor_computed   = out_r.xor_computed;
  assign out_res.sum_stored     = out_r.sum_stored;
  assign out_res.xor_stored     = out_r.xor_stored;
  assign out_res.word_sum       = out_r.word_sum;
  assign out_res.balance_stored = out_r.balance_stored;
  assign out_res.balance_fixed  = out_r.balance_fixed;
  assign out_res.sum_bad        = out_r.sum_bad;
  assign out_res.xor_bad        = out_r.xor_bad;
  assign out_res.word_bad       = out_r.word_bad;

endmodule

// ===== design/rsxb_checker.sv =====
// Port-level assertions for the ROM checker and their bind.
module rsxb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  sum_computed,
  input logic [7:0]  xor_computed,
  input logic [7:0]  sum_stored,
  input logic [7:0]  xor_stored,
  input logic [15:0] word_sum,
  input logic [15:0] balance_stored,
  input logic [15:0] balance_fixed,
  input logic        sum_bad,
  input logic        xor_bad,
  input logic        word_bad
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(word_sum) && $stable(balance_fixed))
    else $error("stalled result changed");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (sum_bad == (sum_computed != sum_stored)) &&
                  (xor_bad == (xor_computed != xor_stored)))
    else $error("sum or xor flag disagrees with values");

  a_balance: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !word_bad |-> balance_fixed == balance_stored)
    else $error("balance moved although word sum matches");

endmodule

bind rom_sum_xor_balance_checker rsxb_checker u_rsxb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .sum_computed   (out_res.sum_computed),
  .xor_computed   (out_res.xor_computed),
  .sum_stored     (out_res.sum_stored),
  .xor_stored     (out_res.xor_stored),
  .word_sum       (out_res.word_sum),
  .balance_stored (out_res.balance_stored),
  .balance_fixed  (out_res.balance_fixed),
  .sum_bad        (out_res.sum_bad),
  .xor_bad        (out_res.xor_bad),
  .word_bad       (out_res.word_bad)
);
